// File: design/frs_pkg.sv
// Shared types and constants for the fixed-radius sweep neighbour unit.
// Holds the transfer payload structs, window entry layout and sequencer states.
// No dependencies.
`default_nettype none

package frs_pkg;

  // Field widths of the point format
  localparam int COORD_W    = 16;
  localparam int ID_W       = 16;
  localparam int RADIUS_W   = 15;
  localparam int SQ_W       = 2 * RADIUS_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index taken from the word address bit
  localparam logic REG_RADIUS = 1'b0;

  // Input command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic                      command;
    logic [ID_W-1:0]           node_id;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] new_node;
    logic [ID_W-1:0] neighbour_node;
    logic            window_overflow;
    logic            last_edge;
  } out_item_t;

  // One stored window point
  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } win_entry_t;

  // Neighbour found at the end of the distance pipeline
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] nb_id;
  } hit_t;

  // Status from the output stage back to the sequencer
  typedef struct packed {
    logic stall;
    logic flush_done;
  } ostat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_SCAN,
    ST_FLUSH,
    ST_APPEND
  } seq_state_t;

  // Absolute difference of two signed coordinates; always fits COORD_W bits
  function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? (~d + 1'b1) : d;
    return m[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: design/frs_window_mem.sv
// Ring window store: one write port, one read port, registered read data.
// Depends on frs_pkg for the entry layout.
`default_nettype none

module frs_window_mem #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [IDX_W-1:0]   waddr,
  input  wire frs_pkg::win_entry_t wdata,
  input  wire logic               re,
  input  wire logic [IDX_W-1:0]   raddr,
  output frs_pkg::win_entry_t     rdata
);
  import frs_pkg::*;

  win_entry_t mem_r [DEPTH];
  win_entry_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: design/frs_dist_pipe.sv
// Distance check pipeline: axis test, squares, then sum against radius squared.
// Depends on frs_pkg; fed from the window memory read port.
`default_nettype none

module frs_dist_pipe (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            adv,
  input  wire logic                            issue,
  input  wire frs_pkg::win_entry_t             rdata,
  input  wire logic signed [frs_pkg::COORD_W-1:0] x,
  input  wire logic signed [frs_pkg::COORD_W-1:0] y,
  input  wire logic [frs_pkg::RADIUS_W-1:0]    radius,
  input  wire logic [frs_pkg::SQ_W-1:0]        r2,
  output frs_pkg::hit_t                        hit,
  output logic                                 busy
);
  import frs_pkg::*;

  logic                iss_v_r;
  logic                s1_v_r;
  logic [RADIUS_W-1:0] s1_dx_r;
  logic [RADIUS_W-1:0] s1_dy_r;
  logic [ID_W-1:0]     s1_id_r;
  logic                s2_v_r;
  logic [SQ_W-1:0]     s2_dx2_r;
  logic [SQ_W-1:0]     s2_dy2_r;
  logic [ID_W-1:0]     s2_id_r;

  logic [COORD_W-1:0]  dx;
  logic [COORD_W-1:0]  dy;
  logic                near;
  logic [SQ_W:0]       dist2;

  // Per-axis distance against the radius
  always_comb begin
    dx   = abs_diff(x, rdata.x);
    dy   = abs_diff(y, rdata.y);
    near = (dx <= COORD_W'(radius)) && (dy <= COORD_W'(radius));
  end

  // Valid bits advance only when the output side can take a hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_v_r <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else if (adv) begin
      iss_v_r <= issue;
      s1_v_r  <= iss_v_r && near;
      s2_v_r  <= s1_v_r;
    end
  end

  // Payload stages: axis distances fit the radius width once near holds
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx_r  <= dx[RADIUS_W-1:0];
      s1_dy_r  <= dy[RADIUS_W-1:0];
      s1_id_r  <= rdata.id;
      s2_dx2_r <= s1_dx_r * s1_dx_r;
      s2_dy2_r <= s1_dy_r * s1_dy_r;
      s2_id_r  <= s1_id_r;
    end
  end

  // Final compare of the squared distance
  assign dist2     = {1'b0, s2_dx2_r} + {1'b0, s2_dy2_r};
  assign hit.valid = s2_v_r && (dist2 <= {1'b0, r2});
  assign hit.nb_id = s2_id_r;
  assign busy      = iss_v_r || s1_v_r || s2_v_r;

endmodule

`default_nettype wire

// File: design/frs_edge_out.sv
// Edge output stage: one pending hit plus the output register, so the last
// edge of a point can be marked. Depends on frs_pkg.
`default_nettype none

module frs_edge_out (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire frs_pkg::hit_t            hit,
  input  wire logic                     flush_req,
  input  wire logic [frs_pkg::ID_W-1:0] new_node,
  input  wire logic                     overflow,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output frs_pkg::out_item_t            out_item,
  output frs_pkg::ostat_t               ostat
);
  import frs_pkg::*;

  logic            pend_v_r;
  logic [ID_W-1:0] pend_id_r;
  logic            out_valid_r;
  out_item_t       out_item_r;

  logic out_free;
  logic push;
  logic flush_fire;
  logic load;

  // A new hit displaces the pending one into the output register
  always_comb begin
    out_free         = !out_valid_r || out_ready;
    ostat.stall      = hit.valid && pend_v_r && !out_free;
    push             = hit.valid && !ostat.stall;
    flush_fire       = flush_req && pend_v_r && out_free;
    load             = (push && pend_v_r) || flush_fire;
    ostat.flush_done = !pend_v_r || out_free;
  end

  // Pending hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (push) begin
      pend_v_r <= 1'b1;
    end else if (flush_fire) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pend_id_r <= hit.nb_id;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r.new_node        <= new_node;
      out_item_r.neighbour_node  <= pend_id_r;
      out_item_r.window_overflow <= overflow;
      out_item_r.last_edge       <= flush_fire;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: design/fixed_radius_sweep_neighbours_unit.sv
// Per added point, E = entries evicted and F = entries left, with E + F <= WINDOW_DEPTH:
// one window read per eviction, one read issue per compare into a three-stage distance
// pipeline, then the last edge is flushed. One point at a time: the next is taken only
// after the point is appended, and output stalls hold the scan; a clear is taken in idle.
// Reset (rst_n, synchronous, active low) empties the window, clears the overflow flag and
// sets radius to 0.
`default_nettype none

module fixed_radius_sweep_neighbours_unit #(
  parameter int WINDOW_DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire frs_pkg::in_item_t                 in_item,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output frs_pkg::out_item_t                     out_item,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [frs_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [frs_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [frs_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                   pready
);
  import frs_pkg::*;

  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

  seq_state_t                state_r, state_nxt;
  logic [IDX_W-1:0]          oldest_r, oldest_nxt;
  logic [FILL_W-1:0]         fill_r, fill_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [FILL_W-1:0]         k_r, k_nxt;
  logic [ID_W-1:0]           id_r;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] y_r;
  logic [RADIUS_W-1:0]       radius_r;
  logic [SQ_W-1:0]           r2_r;

  logic              latch;
  logic              cfg_wr;
  logic              adv;
  logic              issue;
  logic              flush_req;
  logic              pipe_busy;
  logic              win_full;
  logic              evict_far;
  logic [IDX_W-1:0]  oldest_inc;
  logic [FILL_W-1:0] slot_k;
  logic [IDX_W:0]    slot_sum;
  logic [IDX_W-1:0]  slot_idx;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  win_entry_t        mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  win_entry_t        mem_rdata;
  hit_t              hit;
  ostat_t            ostat;

  // Configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RADIUS) ? CFG_DATA_W'(radius_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      r2_r     <= '0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_RADIUS)) begin
        radius_r <= pwdata[RADIUS_W-1:0];
      end
      r2_r <= radius_r * radius_r;
    end
  end

  // Ring arithmetic
  assign win_full   = (fill_r == FILL_W'(WINDOW_DEPTH));
  assign oldest_inc = (oldest_r == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
  assign slot_k     = (state_r == ST_APPEND) ? fill_r : k_r;
  assign slot_sum   = {1'b0, oldest_r} + {1'b0, slot_k[IDX_W-1:0]};
  assign slot_idx   = (slot_sum >= (IDX_W+1)'(WINDOW_DEPTH)) ?
                      slot_sum[IDX_W-1:0] - IDX_W'(WINDOW_DEPTH) : slot_sum[IDX_W-1:0];
  assign evict_far  = abs_diff(x_r, mem_rdata.x) > COORD_W'(radius_r);
  assign adv        = !ostat.stall;
  assign mem_wdata  = '{id: id_r, x: x_r, y: y_r};

  // Sequencer: evict, scan, flush last edge, append
  always_comb begin
    state_nxt  = state_r;
    oldest_nxt = oldest_r;
    fill_nxt   = fill_r;
    ovf_nxt    = ovf_r;
    k_nxt      = k_r;
    in_ready   = 1'b0;
    latch      = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = oldest_r;
    mem_we     = 1'b0;
    mem_waddr  = slot_idx;
    issue      = 1'b0;
    flush_req  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_item.command == CMD_CLEAR) begin
            oldest_nxt = '0;
            fill_nxt   = '0;
            ovf_nxt    = 1'b0;
          end else begin
            latch = 1'b1;
            k_nxt = '0;
            if (fill_r > FILL_W'(1)) begin
              mem_re    = 1'b1;
              mem_raddr = oldest_r;
              state_nxt = ST_EVICT;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_EVICT: begin
        // Drop the oldest entry and fetch the next one in the same cycle
        if ((fill_r > FILL_W'(1)) && evict_far) begin
          oldest_nxt = oldest_inc;
          fill_nxt   = fill_r - 1'b1;
          mem_re     = 1'b1;
          mem_raddr  = oldest_inc;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ovf_nxt = ovf_r | win_full;
        if (k_r < fill_r) begin
          if (adv) begin
            mem_re    = 1'b1;
            mem_raddr = slot_idx;
            issue     = 1'b1;
            k_nxt     = k_r + 1'b1;
          end
        end else if (!pipe_busy) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        flush_req = 1'b1;
        if (ostat.flush_done) begin
          state_nxt = ST_APPEND;
        end
      end
      ST_APPEND: begin
        // A full window overwrites its oldest slot
        mem_we = 1'b1;
        if (win_full) begin
          mem_waddr  = oldest_r;
          oldest_nxt = oldest_inc;
        end else begin
          mem_waddr = slot_idx;
          fill_nxt  = fill_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      oldest_r <= '0;
      fill_r   <= '0;
      ovf_r    <= 1'b0;
      k_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      fill_r   <= fill_nxt;
      ovf_r    <= ovf_nxt;
      k_r      <= k_nxt;
    end
  end

  // Hold the arriving point for the whole step
  always_ff @(posedge clk) begin
    if (latch) begin
      id_r <= in_item.node_id;
      x_r  <= in_item.x_coord;
      y_r  <= in_item.y_coord;
    end
  end

  frs_window_mem #(
    .DEPTH (WINDOW_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  frs_dist_pipe u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .issue  (issue),
    .rdata  (mem_rdata),
    .x      (x_r),
    .y      (y_r),
    .radius (radius_r),
    .r2     (r2_r),
    .hit    (hit),
    .busy   (pipe_busy)
  );

  frs_edge_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .hit       (hit),
    .flush_req (flush_req),
    .new_node  (id_r),
    .overflow  (ovf_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .ostat     (ostat)
  );

  // Window bookkeeping stays in range
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill above depth");

  a_oldest_range: assert property (@(posedge clk) disable iff (!rst_n)
    oldest_r <= IDX_W'(WINDOW_DEPTH - 1))
    else $error("oldest slot out of range");

  // Eviction always keeps the newest entry
  a_evict_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVICT) |-> (fill_r != '0))
    else $error("eviction emptied the window");

  // Scan never issues past the live entries
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (k_r <= fill_r))
    else $error("scan index past fill");

  // Append only after the compare pipeline has drained
  a_append_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_APPEND) |-> !pipe_busy)
    else $error("append while compares in flight");

endmodule

`default_nettype wire
